// ----- rtl/core/gbi_pkg.sv -----
// ----------------------------------------------------------------------------
// gbi_pkg
// Shared constants, types and helpers of the grid bilinear interpolator.
// ----------------------------------------------------------------------------
package gbi_pkg;

  localparam int LAT_ROWS_DEF    = 13;
  localparam int LON_COLS_DEF    = 73;
  localparam int NUM_TABLES_DEF  = 4;
  localparam int VALUE_WIDTH_DEF = 32;

  // beat field widths
  localparam int TSEL_W = 2;
  localparam int LAT_W  = 16;
  localparam int LON_W  = 19;
  localparam int ROWF_W = 4;
  localparam int COLF_W = 7;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_WRITE = 2'd2;

  // one grid step is 1280 = 5 << 8 units of 1/256 degree
  localparam int STEP_UNITS = 1280;
  localparam int STEP_SHIFT = 8;
  localparam int WGT_W      = 11;

  // weight total 1280 * 1280 = 25 << 16
  localparam int RND_SHIFT = 16;
  localparam int RND_HALF  = 819200;
  localparam int DIV_BASE  = 25;
  localparam int DIG_W     = 8;
  localparam int REM_W     = 5;

  localparam int OUT_DEPTH = 16;

  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic              zero;
    logic [STAT_W-1:0] status;
    logic [WGT_W-1:0]  wa;
    logic [WGT_W-1:0]  wb;
  } tok_t;

  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
  } res_ctl_t;

  // one radix-256 digit of a long division by 25, remainder kept below 25
  function automatic logic [REM_W+DIG_W-1:0] div_digit(input logic [REM_W-1:0] rem_in,
                                                       input logic [DIG_W-1:0] dig);
    logic [REM_W:0]   trial;
    logic [REM_W-1:0] r;
    logic [DIG_W-1:0] q;
    r = rem_in;
    q = '0;
    for (int i = DIG_W - 1; i >= 0; i--) begin
      trial = {r, dig[i]};
      if (trial >= (REM_W+1)'(DIV_BASE)) begin
        trial = trial - (REM_W+1)'(DIV_BASE);
        q[i]  = 1'b1;
      end
      r = trial[REM_W-1:0];
    end
    return {r, q};
  endfunction

endpackage

// ----- rtl/core/gbi_req_if.sv -----
// ----------------------------------------------------------------------------
// gbi_req_if
// Request channel: query and table write beats.
// ----------------------------------------------------------------------------
interface gbi_req_if import gbi_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [TSEL_W-1:0]        table_sel;
  logic signed [LAT_W-1:0]  latitude;
  logic signed [LON_W-1:0]  longitude;
  logic [ROWF_W-1:0]        entry_row;
  logic [COLF_W-1:0]        entry_col;
  logic signed [DATA_W-1:0] entry_value;

  modport source (
    output valid, cmd, table_sel, latitude, longitude, entry_row, entry_col, entry_value,
    input  ready
  );

  modport sink (
    input  valid, cmd, table_sel, latitude, longitude, entry_row, entry_col, entry_value,
    output ready
  );

endinterface

// ----- rtl/core/gbi_rsp_if.sv -----
// ----------------------------------------------------------------------------
// gbi_rsp_if
// Response channel: interpolated value and status beats.
// ----------------------------------------------------------------------------
interface gbi_rsp_if import gbi_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic [STAT_W-1:0]        status;

  modport source (
    output valid, value, status,
    input  ready
  );

  modport sink (
    input  valid, value, status,
    output ready
  );

endinterface

// ----- rtl/core/grid_bilinear_interpolator_unit.sv -----
// Throughput: a query holds the single grid memory port for its four corner reads;
//   one write or error beat every cycle, as long as the response side takes beats.
// Reset clears the pipeline and queue control; grid contents stay undefined until written.
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator_unit
// Grid tables in one synchronous memory, four-corner read sequencer, weighted
// multiply-accumulate and rounding division, response queue.
// ----------------------------------------------------------------------------
module grid_bilinear_interpolator_unit import gbi_pkg::*; #(
  parameter int LAT_ROWS    = LAT_ROWS_DEF,
  parameter int LON_COLS    = LON_COLS_DEF,
  parameter int NUM_TABLES  = NUM_TABLES_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gbi_req_if.sink    req,
  gbi_rsp_if.source  rsp
);

  localparam int ROW_W    = $clog2(LAT_ROWS);
  localparam int COL_W    = $clog2(LON_COLS);
  localparam int TBL_AW   = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int AW       = TBL_AW + ROW_W + COL_W;
  localparam int LAT_SPAN = (LAT_ROWS - 1) * STEP_UNITS;
  localparam int LAT_HALF = LAT_SPAN / 2;
  localparam int LON_SPAN = (LON_COLS - 1) * STEP_UNITS;
  localparam int MAX_SPAN = (LAT_SPAN > LON_SPAN) ? LAT_SPAN : LON_SPAN;
  localparam int UPOS_W   = $clog2(MAX_SPAN + 1);
  localparam int SPOS_W   = ((LON_W > UPOS_W) ? LON_W : UPOS_W) + 2;
  localparam int HI_W     = UPOS_W - STEP_SHIFT;
  localparam int RECIP_5  = 205;
  localparam int RECIP_SH = 10;
  localparam int PROD_W   = HI_W + 8;
  localparam int P1W      = VALUE_WIDTH + 12;
  localparam int ACC_W    = VALUE_WIDTH + 24;
  localparam int PTR_W    = $clog2(OUT_DEPTH);
  localparam int CNT_W    = $clog2(OUT_DEPTH + 1);

  localparam logic signed [SPOS_W-1:0] LAT_HALF_S = SPOS_W'(LAT_HALF);
  localparam logic signed [SPOS_W-1:0] LAT_SPAN_S = SPOS_W'(LAT_SPAN);
  localparam logic signed [SPOS_W-1:0] LON_SPAN_S = SPOS_W'(LON_SPAN);
  localparam logic [WGT_W-1:0]         WGT_FULL   = WGT_W'(STEP_UNITS);
  localparam logic [1:0]               LAST_CORNER = 2'd3;

  // --------------------------------------------------------------------------
  // stage 1: latitude range check, longitude wrap
  // --------------------------------------------------------------------------
  logic signed [SPOS_W-1:0] lat_ext, lat_pos, lon_ext, lon_plus, lon_minus, lon_wrap;
  logic                     lat_err;
  logic                     accept;
  logic                     s2_load;

  always_comb begin
    lat_ext   = SPOS_W'(req.latitude);
    lat_pos   = lat_ext + LAT_HALF_S;
    lat_err   = (lat_pos < 0) || (lat_pos > LAT_SPAN_S);
    lon_ext   = SPOS_W'(req.longitude);
    lon_plus  = lon_ext + LON_SPAN_S;
    lon_minus = lon_ext - LON_SPAN_S;
    if (lon_ext < 0) begin
      lon_wrap = (lon_plus < 0) ? '0 : lon_plus;
    end else if (lon_ext > LON_SPAN_S) begin
      lon_wrap = (lon_minus > LON_SPAN_S) ? LON_SPAN_S : lon_minus;
    end else begin
      lon_wrap = lon_ext;
    end
  end

  logic                   s1_vld;
  logic                   s1_cmd;
  logic [TBL_AW-1:0]      s1_tbl;
  logic                   s1_tbl_ok;
  logic                   s1_err;
  logic [UPOS_W-1:0]      s1_lat;
  logic [UPOS_W-1:0]      s1_lon;
  logic                   s1_wr_ok;
  logic [ROW_W-1:0]       s1_wrow;
  logic [COL_W-1:0]       s1_wcol;
  logic [VALUE_WIDTH-1:0] s1_wval;

  assign req.ready = !s1_vld || s2_load;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (accept) begin
      s1_vld <= 1'b1;
    end else if (s2_load) begin
      s1_vld <= 1'b0;
    end
    if (accept) begin
      s1_cmd    <= req.cmd;
      s1_tbl    <= TBL_AW'(req.table_sel);
      s1_tbl_ok <= int'(req.table_sel) < NUM_TABLES;
      s1_err    <= lat_err;
      s1_lat    <= UPOS_W'(lat_pos);
      s1_lon    <= UPOS_W'(lon_wrap);
      s1_wr_ok  <= (int'(req.table_sel) < NUM_TABLES) && (int'(req.entry_row) < LAT_ROWS) &&
                   (int'(req.entry_col) < LON_COLS);
      s1_wrow   <= ROW_W'(req.entry_row);
      s1_wcol   <= COL_W'(req.entry_col);
      s1_wval   <= VALUE_WIDTH'(req.entry_value);
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: grid cell and fractions, divide by 1280 as (x >> 8) * 205 >> 10
  // --------------------------------------------------------------------------
  logic [HI_W-1:0]   lat_q, lon_q;
  logic [PROD_W-1:0] lat_prod, lon_prod;
  logic [UPOS_W-1:0] lat_base, lon_base;
  logic [ROW_W-1:0]  r0_calc;
  logic [COL_W-1:0]  c0_calc;

  always_comb begin
    lat_prod = PROD_W'(s1_lat[UPOS_W-1:STEP_SHIFT]) * PROD_W'(RECIP_5);
    lon_prod = PROD_W'(s1_lon[UPOS_W-1:STEP_SHIFT]) * PROD_W'(RECIP_5);
    lat_q    = HI_W'(lat_prod >> RECIP_SH);
    lon_q    = HI_W'(lon_prod >> RECIP_SH);
    lat_base = UPOS_W'(lat_q) * UPOS_W'(STEP_UNITS);
    lon_base = UPOS_W'(lon_q) * UPOS_W'(STEP_UNITS);
    r0_calc  = ROW_W'(lat_q);
    c0_calc  = COL_W'(lon_q);
  end

  logic                   job_vld;
  logic                   job_single;
  logic                   job_we;
  logic [STAT_W-1:0]      job_status;
  logic [TBL_AW-1:0]      job_tbl;
  logic [ROW_W-1:0]       job_r0, job_r1;
  logic [COL_W-1:0]       job_c0, job_c1;
  logic [WGT_W-1:0]       job_fa, job_fb;
  logic [ROW_W-1:0]       job_wrow;
  logic [COL_W-1:0]       job_wcol;
  logic [VALUE_WIDTH-1:0] job_wval;
  logic                   job_done;

  assign s2_load = s1_vld && (!job_vld || job_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_vld <= 1'b0;
    end else if (s2_load) begin
      job_vld <= 1'b1;
    end else if (job_done) begin
      job_vld <= 1'b0;
    end
    if (s2_load) begin
      job_single <= (s1_cmd == CMD_WRITE) || s1_err || !s1_tbl_ok;
      job_we     <= (s1_cmd == CMD_WRITE) && s1_wr_ok;
      if (s1_cmd == CMD_WRITE) begin
        job_status <= ST_WRITE;
      end else if (s1_err) begin
        job_status <= ST_RANGE;
      end else begin
        job_status <= ST_OK;
      end
      job_tbl  <= s1_tbl;
      job_r0   <= r0_calc;
      job_r1   <= (r0_calc == ROW_W'(LAT_ROWS - 1)) ? r0_calc : r0_calc + 1'b1;
      job_c0   <= c0_calc;
      job_c1   <= (c0_calc == COL_W'(LON_COLS - 1)) ? c0_calc : c0_calc + 1'b1;
      job_fa   <= WGT_W'(s1_lat - lat_base);
      job_fb   <= WGT_W'(s1_lon - lon_base);
      job_wrow <= s1_wrow;
      job_wcol <= s1_wcol;
      job_wval <= s1_wval;
    end
  end

  // --------------------------------------------------------------------------
  // corner sequencer on the single memory port
  // --------------------------------------------------------------------------
  logic [1:0]       step, step_next;
  logic [CNT_W-1:0] pending, pending_next;
  logic             tok_last;
  logic             issue;
  logic             rsp_beat;
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  tok_t             tok0;

  always_comb begin
    tok_last = job_single || (step == LAST_CORNER);
    issue    = job_vld && (!tok_last || (pending < CNT_W'(OUT_DEPTH)));
    job_done = issue && tok_last;
    mem_we   = issue && job_we;
    if (job_we) begin
      mem_addr = {job_tbl, job_wrow, job_wcol};
    end else begin
      mem_addr = {job_tbl, step[1] ? job_r1 : job_r0, step[0] ? job_c1 : job_c0};
    end
    tok0.valid  = issue;
    tok0.first  = (step == 2'd0);
    tok0.last   = tok_last;
    tok0.zero   = job_single;
    tok0.status = job_status;
    tok0.wa     = step[1] ? job_fa : WGT_FULL - job_fa;
    tok0.wb     = step[0] ? job_fb : WGT_FULL - job_fb;
  end

  always_comb begin
    step_next = step;
    if (issue) begin
      step_next = tok_last ? 2'd0 : step + 2'd1;
    end
    pending_next = pending;
    if (job_done && !rsp_beat) begin
      pending_next = pending + 1'b1;
    end else if (!job_done && rsp_beat) begin
      pending_next = pending - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= 2'd0;
      pending <= '0;
    end else begin
      step    <= step_next;
      pending <= pending_next;
    end
  end

  logic [VALUE_WIDTH-1:0] rdata;

  gbi_grid_mem #(
    .AW (AW),
    .DW (VALUE_WIDTH)
  ) u_grid_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (job_wval),
    .rdata (rdata)
  );

  // --------------------------------------------------------------------------
  // weighting and accumulation
  // --------------------------------------------------------------------------
  tok_t                    tok1, tok2, tok3;
  logic signed [P1W-1:0]   p1;
  logic signed [ACC_W-1:0] p2;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] total;
  res_ctl_t                sum_ctl;

  always_comb begin
    acc_next = (tok3.first ? '0 : acc) + p2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok1          <= '0;
      tok2          <= '0;
      tok3          <= '0;
      sum_ctl.valid <= 1'b0;
    end else begin
      tok1          <= tok0;
      tok2          <= tok1;
      tok3          <= tok2;
      sum_ctl.valid <= tok3.valid && tok3.last;
    end
    p1             <= $signed(rdata) * $signed({1'b0, tok1.wa});
    p2             <= p1 * $signed({1'b0, tok2.wb});
    sum_ctl.status <= tok3.status;
    if (tok3.valid) begin
      acc <= acc_next;
    end
    total <= tok3.zero ? '0 : acc_next;
  end

  res_ctl_t                 res_ctl;
  logic signed [DATA_W-1:0] res_value;

  gbi_round_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_round_div (
    .clk       (clk),
    .rst       (rst),
    .sum_ctl   (sum_ctl),
    .total     (total),
    .res_ctl   (res_ctl),
    .res_value (res_value)
  );

  // --------------------------------------------------------------------------
  // response queue, space reserved by the pending count
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] q_value  [OUT_DEPTH];
  logic [STAT_W-1:0]        q_status [OUT_DEPTH];
  logic [PTR_W-1:0]         wptr, rptr;
  logic [CNT_W-1:0]         fill, fill_next;

  assign rsp.valid  = (fill != '0);
  assign rsp.value  = q_value[rptr];
  assign rsp.status = q_status[rptr];
  assign rsp_beat   = rsp.valid && rsp.ready;

  always_comb begin
    fill_next = fill;
    if (res_ctl.valid && !rsp_beat) begin
      fill_next = fill + 1'b1;
    end else if (!res_ctl.valid && rsp_beat) begin
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      fill <= fill_next;
      if (res_ctl.valid) begin
        wptr <= wptr + 1'b1;
      end
      if (rsp_beat) begin
        rptr <= rptr + 1'b1;
      end
    end
    if (res_ctl.valid) begin
      q_value[wptr]  <= res_value;
      q_status[wptr] <= res_ctl.status;
    end
  end

endmodule

// ----- rtl/core/gbi_grid_mem.sv -----
// ----------------------------------------------------------------------------
// gbi_grid_mem
// Single-port grid table store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module gbi_grid_mem #(
  parameter int AW = 13,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/gbi_round_div.sv -----
// ----------------------------------------------------------------------------
// gbi_round_div
// Rounds the weighted sum to nearest (ties away from zero) and divides it by
// the weight total through a pipelined radix-256 long division by 25.
// ----------------------------------------------------------------------------
module gbi_round_div import gbi_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  res_ctl_t                          sum_ctl,
  input  logic signed [VALUE_WIDTH+23:0]    total,
  output res_ctl_t                          res_ctl,
  output logic signed [DATA_W-1:0]          res_value
);

  localparam int ACC_W = VALUE_WIDTH + 24;
  localparam int XW    = ACC_W - RND_SHIFT;
  localparam int NDIG  = (XW + DIG_W - 1) / DIG_W;
  localparam int XP    = NDIG * DIG_W;

  localparam logic [ACC_W-1:0] HALF_POS = ACC_W'(RND_HALF);
  localparam logic [ACC_W-1:0] HALF_NEG = ACC_W'(RND_HALF + 1);

  logic              vld    [NDIG+1];
  logic [STAT_W-1:0] status [NDIG+1];
  logic              neg    [NDIG+1];
  logic [XP-1:0]     xin    [NDIG+1];
  logic [REM_W-1:0]  rem    [NDIG+1];
  logic [XP-1:0]     quo    [NDIG+1];

  logic [ACC_W-1:0] mag;
  logic             sum_neg;

  // |s| + half in one add: for negative s, ~s + 1 + half
  always_comb begin
    sum_neg = total[ACC_W-1];
    mag     = sum_neg ? (~total + HALF_NEG) : (total + HALF_POS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= sum_ctl.valid;
    end
    status[0] <= sum_ctl.status;
    neg[0]    <= sum_neg;
    xin[0]    <= XP'(mag[ACC_W-1:RND_SHIFT]);
    rem[0]    <= '0;
    quo[0]    <= '0;
  end

  for (genvar j = 1; j <= NDIG; j++) begin : g_digit
    localparam int POS = XP - 1 - (j - 1) * DIG_W;
    logic [REM_W+DIG_W-1:0] step;
    logic [XP-1:0]          quo_in;

    always_comb begin
      step                 = div_digit(rem[j-1], xin[j-1][POS -: DIG_W]);
      quo_in               = quo[j-1];
      quo_in[POS -: DIG_W] = step[DIG_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= vld[j-1];
      end
      status[j] <= status[j-1];
      neg[j]    <= neg[j-1];
      xin[j]    <= xin[j-1];
      rem[j]    <= step[REM_W+DIG_W-1:DIG_W];
      quo[j]    <= quo_in;
    end
  end

  logic signed [VALUE_WIDTH:0] mag_q;
  logic signed [VALUE_WIDTH:0] signed_q;

  always_comb begin
    mag_q          = $signed({1'b0, quo[NDIG][VALUE_WIDTH-1:0]});
    signed_q       = neg[NDIG] ? -mag_q : mag_q;
    res_value      = DATA_W'(signed_q);
    res_ctl.valid  = vld[NDIG];
    res_ctl.status = status[NDIG];
  end

endmodule

// ----- rtl/core/gbi_checker.sv -----
// ----------------------------------------------------------------------------
// gbi_checker
// Port-level checks of the grid bilinear interpolator response channel.
// ----------------------------------------------------------------------------
module gbi_checker import gbi_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic signed [DATA_W-1:0] rsp_value,
  input logic [STAT_W-1:0]        rsp_status
);

  a_rsp_hold : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
    else $error("response beat changed while stalled");

  a_zero_value : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_value == '0)
    else $error("write or range error beat carries a non-zero value");

  a_status_code : assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_RANGE || rsp_status == ST_WRITE)
    else $error("unknown status on response");

  a_reset_quiet : assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("response valid straight after reset");

endmodule

bind grid_bilinear_interpolator_unit gbi_checker u_gbi_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_value  (rsp.value),
  .rsp_status (rsp.status)
);

// ----- tb/grid_bilinear_interpolator_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator_unit_tb
// Loads the L value table in full, then runs a directed set of beats (value
// extremes, grid corners, longitude wrap and saturation, latitude range
// errors, writes outside the tables) and a random mix of writes to any table
// and queries of the L value table. Every response beat is compared with an
// expected beat from the directed table or a bilinear predictor in the bench.
// Both channels idle in random bursts, and the response side holds off once
// for a long stretch.
// ----------------------------------------------------------------------------
module grid_bilinear_interpolator_unit_tb;
  import gbi_pkg::*;

  localparam int TBL_LVAL  = 0;
  localparam int TBL_FIELD = 1;
  localparam int TBL_GLAT  = 2;
  localparam int TBL_GLON  = 3;

  localparam int LAT_SPAN     = (LAT_ROWS_DEF - 1) * STEP_UNITS;
  localparam int LAT_HALF     = LAT_SPAN / 2;
  localparam int LAT_LIMIT    = 3 * LAT_HALF;
  localparam int LON_SPAN     = (LON_COLS_DEF - 1) * STEP_UNITS;
  localparam int WEIGHT_TOTAL = STEP_UNITS * STEP_UNITS;
  localparam int VAL_MAX      = 32'h7fff_ffff;
  localparam int VAL_MIN      = int'(32'h8000_0000);

  localparam int RANDOM_BEATS = 676;
  localparam int TAIL_BEATS   = 150;
  localparam int HOLD_AT      = 400;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic                     cmd;
    logic [TSEL_W-1:0]        tsel;
    logic signed [LAT_W-1:0]  lat;
    logic signed [LON_W-1:0]  lon;
    logic [ROWF_W-1:0]        row;
    logic [COLF_W-1:0]        col;
    logic signed [DATA_W-1:0] val;
  } req_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [STAT_W-1:0]        status;
  } rsp_beat_t;

  typedef struct packed {
    req_beat_t beat;
    logic      known;
    rsp_beat_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  gbi_req_if req ();
  gbi_rsp_if rsp ();

  grid_bilinear_interpolator_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic signed [DATA_W-1:0] grid_tab [NUM_TABLES_DEF][LAT_ROWS_DEF][LON_COLS_DEF];
  rsp_beat_t pending_results [$];
  dir_row_t  dir_rows [$];
  int        mismatch_count = 0;
  int        beats_sent = 0;
  int        gap_odds = 4;
  bit        steady_tail = 1'b0;
  bit        long_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rsp_beat_t bilinear_result(input req_beat_t b);
    rsp_beat_t r;
    longint    lat_u, lon_w, fa, fb, acc, q;
    int        t, r0, r1, c0, c1;
    r.value  = '0;
    r.status = ST_OK;
    t = int'(b.tsel);
    if (b.cmd == CMD_WRITE) begin
      if (t < NUM_TABLES_DEF && b.row < LAT_ROWS_DEF && b.col < LON_COLS_DEF)
        grid_tab[t][b.row][b.col] = b.val;
      r.status = ST_WRITE;
      return r;
    end
    lat_u = longint'(b.lat) + LAT_HALF;
    if (lat_u < 0 || lat_u > LAT_SPAN) begin
      r.status = ST_RANGE;
      return r;
    end
    lon_w = longint'(b.lon);
    if (lon_w < 0) lon_w = lon_w + LON_SPAN;
    if (lon_w > LON_SPAN) lon_w = lon_w - LON_SPAN;
    if (lon_w < 0) lon_w = 0;
    if (lon_w > LON_SPAN) lon_w = LON_SPAN;
    if (t >= NUM_TABLES_DEF) return r;
    r0 = int'(lat_u / STEP_UNITS);
    fa = lat_u % STEP_UNITS;
    c0 = int'(lon_w / STEP_UNITS);
    fb = lon_w % STEP_UNITS;
    r1 = (r0 + 1 < LAT_ROWS_DEF) ? r0 + 1 : r0;
    c1 = (c0 + 1 < LON_COLS_DEF) ? c0 + 1 : c0;
    acc = longint'(grid_tab[t][r0][c0]) * ((STEP_UNITS - fa) * (STEP_UNITS - fb))
        + longint'(grid_tab[t][r0][c1]) * ((STEP_UNITS - fa) * fb)
        + longint'(grid_tab[t][r1][c0]) * (fa * (STEP_UNITS - fb))
        + longint'(grid_tab[t][r1][c1]) * (fa * fb);
    if (acc >= 0) q = (acc + WEIGHT_TOTAL / 2) / WEIGHT_TOTAL;
    else          q = -((-acc + WEIGHT_TOTAL / 2) / WEIGHT_TOTAL);
    r.value = DATA_W'(q);
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] table_value();
    case ($urandom_range(7))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_beat_t random_beat();
    req_beat_t b;
    int        lat, lon;
    b.cmd  = CMD_QUERY;
    b.tsel = TSEL_W'($urandom_range(NUM_TABLES_DEF - 1));
    b.row  = ROWF_W'($urandom);
    b.col  = COLF_W'($urandom);
    b.val  = $urandom;
    if ($urandom_range(99) < 22) begin
      b.cmd = CMD_WRITE;
      b.val = table_value();
      // mostly in the tables, now and then anywhere the fields reach
      if ($urandom_range(15) != 0) begin
        b.row = ROWF_W'($urandom_range(LAT_ROWS_DEF - 1));
        b.col = COLF_W'($urandom_range(LON_COLS_DEF - 1));
      end
    end
    // only the fully loaded table is queried
    if (b.cmd == CMD_QUERY) b.tsel = TSEL_W'(TBL_LVAL);
    case ($urandom_range(9))
      0: lat = $urandom_range(1) ? LAT_HALF : -LAT_HALF;
      1: begin
        lat = int'($urandom_range(LAT_LIMIT, LAT_HALF + 1));
        if ($urandom_range(1)) lat = -lat;
      end
      2: lat = (int'($urandom_range(LAT_ROWS_DEF - 1)) - (LAT_ROWS_DEF - 1) / 2) * STEP_UNITS;
      default: lat = int'($urandom_range(2 * LAT_HALF)) - LAT_HALF;
    endcase
    case ($urandom_range(11))
      0: lon = 0;
      1: lon = LON_SPAN;
      2: lon = -LON_SPAN;
      3: lon = 2 * LON_SPAN;
      4: lon = (int'($urandom_range(3 * (LON_COLS_DEF - 1))) - (LON_COLS_DEF - 1)) * STEP_UNITS;
      default: lon = int'($urandom_range(3 * LON_SPAN)) - LON_SPAN;
    endcase
    b.lat = LAT_W'(lat);
    b.lon = LON_W'(lon);
    return b;
  endfunction

  function automatic dir_row_t dir_row(input logic c, input int tsel, input int lat,
                                       input int lon, input int row, input int col,
                                       input int val, input logic known, input int want_val,
                                       input logic [STAT_W-1:0] want_st);
    dir_row_t d;
    d.beat.cmd    = c;
    d.beat.tsel   = TSEL_W'(tsel);
    d.beat.lat    = LAT_W'(lat);
    d.beat.lon    = LON_W'(lon);
    d.beat.row    = ROWF_W'(row);
    d.beat.col    = COLF_W'(col);
    d.beat.val    = DATA_W'(val);
    d.known       = known;
    d.want.value  = DATA_W'(want_val);
    d.want.status = want_st;
    return d;
  endfunction

  // called just after a falling edge, returns just after a falling edge
  task automatic send_beat(input req_beat_t b, input logic known, input rsp_beat_t typed);
    rsp_beat_t pred;
    req.valid       <= 1'b1;
    req.cmd         <= b.cmd;
    req.table_sel   <= b.tsel;
    req.latitude    <= b.lat;
    req.longitude   <= b.lon;
    req.entry_row   <= b.row;
    req.entry_col   <= b.col;
    req.entry_value <= b.val;
    do @(posedge clk); while (!req.ready);
    pred = bilinear_result(b);
    pending_results.push_back(known ? typed : pred);
    beats_sent++;
    if (beats_sent % 128 == 0) begin
      case ($urandom_range(3))
        0: gap_odds = 0;
        1: gap_odds = 2;
        2: gap_odds = 6;
        default: gap_odds = 12;
      endcase
    end
    @(negedge clk);
    if (!steady_tail && gap_odds != 0 && $urandom_range(gap_odds - 1) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(negedge clk);
    end
  endtask

  // stimulus
  initial begin
    req_beat_t b;
    rsp_beat_t none;
    req.valid       = 1'b0;
    req.cmd         = CMD_QUERY;
    req.table_sel   = '0;
    req.latitude    = '0;
    req.longitude   = '0;
    req.entry_row   = '0;
    req.entry_col   = '0;
    req.entry_value = '0;
    none            = '0;
    rst             = 1'b1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // the queried table is written in full before any query can touch it
    for (int r = 0; r < LAT_ROWS_DEF; r++)
      for (int c = 0; c < LON_COLS_DEF; c++) begin
        b      = '0;
        b.cmd  = CMD_WRITE;
        b.tsel = TSEL_W'(TBL_LVAL);
        b.row  = ROWF_W'(r);
        b.col  = COLF_W'(c);
        b.val  = table_value();
        send_beat(b, 1'b0, none);
      end

    dir_rows = '{
      dir_row(CMD_WRITE, TBL_LVAL,  0, 0, 0, 0, VAL_MAX, 1'b1, 0, ST_WRITE),
      dir_row(CMD_WRITE, TBL_LVAL,  0, 0, 0, 1, VAL_MIN, 1'b1, 0, ST_WRITE),
      dir_row(CMD_WRITE, TBL_GLON,  0, 0, 12, 72, -1, 1'b1, 0, ST_WRITE),
      dir_row(CMD_WRITE, TBL_FIELD, 0, 0, 12, 72, 32'h5555_5555, 1'b1, 0, ST_WRITE),
      dir_row(CMD_WRITE, TBL_GLAT,  0, 0, 12, 72, 32'haaaa_aaaa, 1'b1, 0, ST_WRITE),
      // rows and columns past the grid are dropped
      dir_row(CMD_WRITE, TBL_FIELD, 0, 0, 15, 5, 123, 1'b1, 0, ST_WRITE),
      dir_row(CMD_WRITE, TBL_GLAT,  0, 0, 3, 127, 456, 1'b1, 0, ST_WRITE),
      dir_row(CMD_QUERY, TBL_LVAL,  -LAT_HALF, 0, 0, 0, 0, 1'b1, VAL_MAX, ST_OK),
      dir_row(CMD_QUERY, TBL_LVAL,  -LAT_HALF, STEP_UNITS, 0, 0, 0, 1'b1, VAL_MIN, ST_OK),
      dir_row(CMD_QUERY, TBL_LVAL,  -LAT_HALF, STEP_UNITS / 2, 0, 0, 0, 1'b0, 0, ST_OK),
      // top corner, both neighbours clamped
      dir_row(CMD_QUERY, TBL_GLON,  LAT_HALF, LON_SPAN, 0, 0, 0, 1'b1, -1, ST_OK),
      dir_row(CMD_QUERY, TBL_FIELD, LAT_HALF, LON_SPAN, 0, 0, 0, 1'b1, 32'h5555_5555, ST_OK),
      dir_row(CMD_QUERY, TBL_GLAT,  LAT_HALF, LON_SPAN, 0, 0, 0, 1'b1, 32'haaaa_aaaa, ST_OK),
      // longitude wrap at both ends
      dir_row(CMD_QUERY, TBL_LVAL,  -LAT_HALF, -LON_SPAN, 0, 0, 0, 1'b1, VAL_MAX, ST_OK),
      dir_row(CMD_QUERY, TBL_GLON,  LAT_HALF, 2 * LON_SPAN, 0, 0, 0, 1'b1, -1, ST_OK),
      // still outside after one wrap, saturated
      dir_row(CMD_QUERY, TBL_GLON,  LAT_HALF, 262143, 0, 0, 0, 1'b1, -1, ST_OK),
      dir_row(CMD_QUERY, TBL_LVAL,  -LAT_HALF, -262144, 0, 0, 0, 1'b1, VAL_MAX, ST_OK),
      // latitude just and far beyond the rows
      dir_row(CMD_QUERY, TBL_LVAL,  LAT_HALF + 1, 0, 0, 0, 0, 1'b1, 0, ST_RANGE),
      dir_row(CMD_QUERY, TBL_FIELD, -LAT_HALF - 1, 0, 0, 0, 0, 1'b1, 0, ST_RANGE),
      dir_row(CMD_QUERY, TBL_GLAT,  LAT_LIMIT, 2 * LON_SPAN, 0, 0, 0, 1'b1, 0, ST_RANGE),
      dir_row(CMD_QUERY, TBL_GLON,  -LAT_LIMIT, -LON_SPAN, 0, 0, 0, 1'b1, 0, ST_RANGE),
      dir_row(CMD_QUERY, TBL_LVAL,  -1, -1, 0, 0, 0, 1'b0, 0, ST_OK),
      dir_row(CMD_QUERY, TBL_LVAL,  3333, 45678, 0, 0, 0, 1'b0, 0, ST_OK),
      dir_row(CMD_QUERY, TBL_LVAL,  0, LON_SPAN, 0, 0, 0, 1'b0, 0, ST_OK),
      dir_row(CMD_QUERY, TBL_LVAL,  LAT_HALF, 17, 0, 0, 0, 1'b0, 0, ST_OK)
    };
    foreach (dir_rows[i])
      send_beat(dir_rows[i].beat, dir_rows[i].known, dir_rows[i].want);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == HOLD_AT) long_hold_req = 1'b1;
      if (n == RANDOM_BEATS - TAIL_BEATS) steady_tail = 1'b1;
      send_beat(random_beat(), 1'b0, none);
    end
    req.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // response side back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    rsp.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD - 1;
        rsp.ready    <= 1'b0;
      end else if (!steady_tail && $urandom_range(7) == 0) begin
        stall_left = int'($urandom_range(13));
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // response checks
  initial begin
    rsp_beat_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected beat, value %0d status %0d", $time, rsp.value, rsp.status);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.value !== want.value) begin
            $display("%0t: value expected %0d actual %0d", $time, want.value, rsp.value);
            mismatch_count++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/gbi_pkg.sv
rtl/core/gbi_req_if.sv
rtl/core/gbi_rsp_if.sv
rtl/core/gbi_grid_mem.sv
rtl/core/gbi_round_div.sv
rtl/core/grid_bilinear_interpolator_unit.sv
rtl/core/gbi_checker.sv
tb/grid_bilinear_interpolator_unit_tb.sv
